[src/sound_triggered_mode_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// sound triggered mode sequencer - assertion macros
// concurrent checks, left out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef SOUND_TRIGGERED_MODE_SEQUENCER_CORE_ASSERT_SVH
`define SOUND_TRIGGERED_MODE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define STMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define STMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STMS_ASSERT(label, clk, rst_n, prop, msg)
`define STMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/stms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stms_pkg
// shared types, register codes and reset values of the mode sequencer
// ----------------------------------------------------------------------------
package stms_pkg;

    localparam int STMS_TIME_BITS = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int SAMPLE_W       = 16;
    localparam int NOW_W          = 32;
    localparam int FRAME_W        = 5;
    localparam int MODE_W         = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIDE_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIDE_PERIOD   = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_LOUD_LEVEL    = 16'd2500;
    localparam logic [CFG_DATA_W-1:0] RST_DASH_DURATION = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] RST_HIDE_DURATION = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] RST_IDLE_PERIOD   = 16'd180;
    localparam logic [CFG_DATA_W-1:0] RST_DASH_PERIOD   = 16'd45;
    localparam logic [CFG_DATA_W-1:0] RST_HIDE_PERIOD   = 16'd220;

    // frame ranges per mode
    localparam logic [FRAME_W-1:0] IDLE_FRM_LO = 5'd0;
    localparam logic [FRAME_W-1:0] IDLE_FRM_HI = 5'd9;
    localparam logic [FRAME_W-1:0] DASH_FRM_LO = 5'd10;
    localparam logic [FRAME_W-1:0] DASH_FRM_HI = 5'd19;
    localparam logic [FRAME_W-1:0] HIDE_FRM_LO = 5'd20;
    localparam logic [FRAME_W-1:0] HIDE_FRM_HI = 5'd24;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] loud_level;
        logic [CFG_DATA_W-1:0] dash_duration;
        logic [CFG_DATA_W-1:0] hide_duration;
        logic [CFG_DATA_W-1:0] idle_period;
        logic [CFG_DATA_W-1:0] dash_period;
        logic [CFG_DATA_W-1:0] hide_period;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] frame;
        logic               show_frame;
    } t_result;

endpackage

[src/stms_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stms_cfg_regs
// configuration register file, written through the index/data write port
// ----------------------------------------------------------------------------
module stms_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [stms_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [stms_pkg::CFG_DATA_W-1:0] i_wr_data,
    output stms_pkg::t_cfg                  o_cfg
);

    stms_pkg::t_cfg r_cfg;
    stms_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                stms_pkg::REG_LOUD_LEVEL:    n_cfg.loud_level    = i_wr_data;
                stms_pkg::REG_DASH_DURATION: n_cfg.dash_duration = i_wr_data;
                stms_pkg::REG_HIDE_DURATION: n_cfg.hide_duration = i_wr_data;
                stms_pkg::REG_IDLE_PERIOD:   n_cfg.idle_period   = i_wr_data;
                stms_pkg::REG_DASH_PERIOD:   n_cfg.dash_period   = i_wr_data;
                stms_pkg::REG_HIDE_PERIOD:   n_cfg.hide_period   = i_wr_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loud_level    <= stms_pkg::RST_LOUD_LEVEL;
            r_cfg.dash_duration <= stms_pkg::RST_DASH_DURATION;
            r_cfg.hide_duration <= stms_pkg::RST_HIDE_DURATION;
            r_cfg.idle_period   <= stms_pkg::RST_IDLE_PERIOD;
            r_cfg.dash_period   <= stms_pkg::RST_DASH_PERIOD;
            r_cfg.hide_period   <= stms_pkg::RST_HIDE_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/stms_peak.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stms_peak
// running peak of sample magnitudes, cleared after each chunk
// ----------------------------------------------------------------------------
`include "sound_triggered_mode_sequencer_core_assert.svh"

module stms_peak (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic signed [stms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_chunk_end,
    output logic        [stms_pkg::SAMPLE_W-1:0] o_peak
);

    logic [stms_pkg::SAMPLE_W-1:0] r_run;
    logic [stms_pkg::SAMPLE_W-1:0] n_run;
    logic [stms_pkg::SAMPLE_W-1:0] mag;
    logic [stms_pkg::SAMPLE_W-1:0] cand;

    // most negative sample wraps to 0x8000, its true magnitude
    assign mag  = i_sample[stms_pkg::SAMPLE_W-1] ?
                  stms_pkg::SAMPLE_W'(~i_sample + 1'b1) : i_sample;
    assign cand = (mag > r_run) ? mag : r_run;

    always_comb begin
        n_run = r_run;
        if (i_fire) begin
            n_run = i_chunk_end ? '0 : cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else begin
            r_run <= n_run;
        end
    end

    assign o_peak = cand;

    `STMS_ASSERT(a_peak_bound, i_clk, i_rst_n, r_run <= 16'h8000, "running peak above full scale")

endmodule

[src/stms_mode_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stms_mode_fsm
// idle / dash / hide mode machine with per-mode frame countdown
// ----------------------------------------------------------------------------
`include "sound_triggered_mode_sequencer_core_assert.svh"

module stms_mode_fsm #(
    parameter int TIME_BITS = stms_pkg::STMS_TIME_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_eval,
    input  logic [stms_pkg::SAMPLE_W-1:0]   i_peak,
    input  logic [stms_pkg::NOW_W-1:0]      i_now_ms,
    input  stms_pkg::t_cfg                  i_cfg,
    output stms_pkg::t_result               o_result
);

    typedef enum logic [stms_pkg::MODE_W-1:0] {
        ST_IDLE = 2'd0,
        ST_DASH = 2'd1,
        ST_HIDE = 2'd2
    } t_mode;

    t_mode                          r_mode,  n_mode;
    logic [stms_pkg::FRAME_W-1:0]   r_frame, n_frame;
    logic [TIME_BITS-1:0]           r_start, n_start;
    logic [TIME_BITS-1:0]           r_last,  n_last;

    t_mode                          cur_mode;
    t_mode                          target;
    logic                           entered;
    logic                           show;
    logic                           sound;
    logic [TIME_BITS-1:0]           now;
    logic [TIME_BITS-1:0]           el_start;
    logic [TIME_BITS-1:0]           el_frame;
    logic [stms_pkg::CFG_DATA_W-1:0] period;
    logic [stms_pkg::FRAME_W-1:0]   first_f;
    logic [stms_pkg::FRAME_W-1:0]   last_f;

    function automatic logic [stms_pkg::FRAME_W-1:0] last_of(t_mode m);
        logic [stms_pkg::FRAME_W-1:0] f;
        unique case (m)
            ST_DASH: f = stms_pkg::DASH_FRM_HI;
            ST_HIDE: f = stms_pkg::HIDE_FRM_HI;
            default: f = stms_pkg::IDLE_FRM_HI;
        endcase
        return f;
    endfunction

    assign now      = TIME_BITS'(i_now_ms);
    assign el_start = now - r_start;
    assign el_frame = now - r_last;
    assign sound    = i_peak > i_cfg.loud_level;

    always_comb begin
        unique case (r_mode)
            ST_DASH: cur_mode = ST_DASH;
            ST_HIDE: cur_mode = ST_HIDE;
            default: cur_mode = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (cur_mode)
            ST_DASH: begin
                period  = i_cfg.dash_period;
                first_f = stms_pkg::DASH_FRM_LO;
                last_f  = stms_pkg::DASH_FRM_HI;
            end
            ST_HIDE: begin
                period  = i_cfg.hide_period;
                first_f = stms_pkg::HIDE_FRM_LO;
                last_f  = stms_pkg::HIDE_FRM_HI;
            end
            default: begin
                period  = i_cfg.idle_period;
                first_f = stms_pkg::IDLE_FRM_LO;
                last_f  = stms_pkg::IDLE_FRM_HI;
            end
        endcase
    end

    always_comb begin
        n_mode  = cur_mode;
        n_frame = r_frame;
        n_start = r_start;
        n_last  = r_last;
        entered = 1'b0;
        target  = cur_mode;
        show    = 1'b0;

        unique case (cur_mode)
            ST_DASH: begin
                if (el_start >= TIME_BITS'(i_cfg.dash_duration)) begin
                    entered = 1'b1;
                    target  = ST_HIDE;
                end else if (sound) begin
                    // fresh sound keeps the dash going
                    n_start = now;
                end
            end
            ST_HIDE: begin
                if (el_start >= TIME_BITS'(i_cfg.hide_duration)) begin
                    entered = 1'b1;
                    target  = ST_IDLE;
                end else if (sound) begin
                    entered = 1'b1;
                    target  = ST_DASH;
                end
            end
            default: begin
                if (sound) begin
                    entered = 1'b1;
                    target  = ST_DASH;
                end
            end
        endcase

        if (entered) begin
            n_mode  = target;
            n_start = now;
            n_last  = now;
            n_frame = last_of(target);
            show    = 1'b1;
        end else if (el_frame >= TIME_BITS'(period)) begin
            // count down and wrap inside the mode's frame range
            if (r_frame <= first_f || r_frame > last_f) begin
                n_frame = last_f;
            end else begin
                n_frame = r_frame - 1'b1;
            end
            n_last = now;
            show   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ST_IDLE;
            r_frame <= stms_pkg::IDLE_FRM_HI;
            r_start <= '0;
            r_last  <= '0;
        end else if (i_eval) begin
            r_mode  <= n_mode;
            r_frame <= n_frame;
            r_start <= n_start;
            r_last  <= n_last;
        end
    end

    assign o_result.mode       = n_mode;
    assign o_result.frame      = n_frame;
    assign o_result.show_frame = show;

    `STMS_ASSERT(a_enter_shows, i_clk, i_rst_n, !(i_eval && n_mode != r_mode) || show, "mode change without frame show")
    `STMS_ASSERT_NEXT(a_frame_hold, i_clk, i_rst_n, i_eval && !show, $stable(r_frame), "frame moved without show")
    `STMS_ASSERT(a_frame_range, i_clk, i_rst_n, (r_mode == ST_IDLE && r_frame <= stms_pkg::IDLE_FRM_HI) || (r_mode == ST_DASH && r_frame >= stms_pkg::DASH_FRM_LO && r_frame <= stms_pkg::DASH_FRM_HI) || (r_mode == ST_HIDE && r_frame >= stms_pkg::HIDE_FRM_LO && r_frame <= stms_pkg::HIDE_FRM_HI), "frame outside mode range")

endmodule

[src/sound_triggered_mode_sequencer_core.sv]
`timescale 1ns / 1ps
// a chunk_end request goes through the input register, then the result register, to o_valid
// throughput: one request per cycle while o_stall is low; one pass from input to result register
// requests without chunk_end update the peak only and give no result
// an output stall backs up into o_stall only when a chunk_end request is waiting
// synchronous active-low reset: idle mode, frame 9, times and peak cleared, registers at defaults
// ----------------------------------------------------------------------------
// sound_triggered_mode_sequencer_core
// peak tracking of microphone samples driving an idle/dash/hide frame sequencer
// ----------------------------------------------------------------------------
`include "sound_triggered_mode_sequencer_core_assert.svh"

module sound_triggered_mode_sequencer_core #(
    parameter int TIME_BITS = stms_pkg::STMS_TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [stms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_chunk_end,
    input  logic        [stms_pkg::NOW_W-1:0]    i_now_ms,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic        [stms_pkg::MODE_W-1:0]   o_mode,
    output logic        [stms_pkg::FRAME_W-1:0]  o_frame,
    output logic                                o_show_frame,
    output logic        [stms_pkg::SAMPLE_W-1:0] o_chunk_peak,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [stms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [stms_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // input register
    logic                                r_in_valid;
    logic signed [stms_pkg::SAMPLE_W-1:0] r_in_sample;
    logic                                r_in_chunk_end;
    logic        [stms_pkg::NOW_W-1:0]    r_in_now;

    // result register
    logic                                r_out_valid;
    stms_pkg::t_result                   r_out_res;
    logic        [stms_pkg::SAMPLE_W-1:0] r_out_peak;

    logic                                in_accept;
    logic                                out_free;
    logic                                fire;
    logic                                eval;
    logic        [stms_pkg::SAMPLE_W-1:0] peak;
    stms_pkg::t_cfg                      cfg;
    stms_pkg::t_result                   res;

    assign out_free  = !r_out_valid || !i_stall;
    // a sample with no result moves on regardless of the output side
    assign fire      = r_in_valid && (!r_in_chunk_end || out_free);
    assign eval      = fire && r_in_chunk_end;
    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    stms_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    stms_peak u_peak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_sample    (r_in_sample),
        .i_chunk_end (r_in_chunk_end),
        .o_peak      (peak)
    );

    stms_mode_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_eval   (eval),
        .i_peak   (peak),
        .i_now_ms (r_in_now),
        .i_cfg    (cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (eval) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample    <= i_sample;
            r_in_chunk_end <= i_chunk_end;
            r_in_now       <= i_now_ms;
        end
        if (eval) begin
            r_out_res  <= res;
            r_out_peak <= peak;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mode       = r_out_res.mode;
    assign o_frame      = r_out_res.frame;
    assign o_show_frame = r_out_res.show_frame;
    assign o_chunk_peak = r_out_peak;

    `STMS_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid, "stalled result dropped")
    `STMS_ASSERT(a_no_overwrite, i_clk, i_rst_n, !(eval && r_out_valid && i_stall), "result overwritten while stalled")

endmodule
